FILE: src/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define IPRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define IPRL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/iprl_pkg.sv
`timescale 1ns / 1ps

package iprl_pkg;

    localparam int PFX_AW       = 16;
    localparam int REC_AW       = 16;
    localparam int RECORD_DEPTH = 65536;
    localparam int CNT_W        = 17;
    localparam int IP_W         = 32;
    localparam int OFF_W        = 24;
    localparam int LEN_W        = 16;
    localparam int REC_W        = IP_W + OFF_W + LEN_W;
    localparam int S_TDATA_W    = 136;
    localparam int M_TDATA_W    = 40;
    localparam int CMD_W        = 2;

    localparam logic [CNT_W-1:0] REC_LIMIT = CNT_W'(RECORD_DEPTH);

    // request kinds carried in s_axis_tuser
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [PFX_AW-1:0] waddr;
        logic [REC_AW-1:0] wdata;
        logic [PFX_AW-1:0] raddr;
    } pfx_port_t;

    // record word: end address, text offset, text length from the top down
    typedef struct packed {
        logic              we;
        logic [REC_AW-1:0] waddr;
        logic [REC_W-1:0]  wdata;
        logic [REC_AW-1:0] raddr;
    } rec_port_t;

endpackage

FILE: src/iprl_ram.sv
`timescale 1ns / 1ps

module iprl_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/iprl_ctrl.sv
`timescale 1ns / 1ps

module iprl_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [iprl_pkg::CNT_W-1:0]          limit,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [iprl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic [iprl_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [iprl_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,
    output iprl_pkg::pfx_port_t                 pfx_port,
    output iprl_pkg::rec_port_t                 rec_port,
    input  logic [iprl_pkg::REC_AW-1:0]         pfx_rdata,
    input  logic [iprl_pkg::REC_W-1:0]          rec_rdata
);

    import iprl_pkg::*;

    state_t state_reg, state_next;

    logic [IP_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0] res_off_reg, res_off_next;
    logic [LEN_W-1:0] res_len_reg, res_len_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [OFF_W-1:0] m_off_reg, m_off_next;
    logic [LEN_W-1:0] m_len_reg, m_len_next;

    // request fields
    logic [IP_W-1:0]   in_ip;
    logic [REC_AW-1:0] in_slot;
    logic [REC_AW-1:0] in_start;
    logic [IP_W-1:0]   in_end;
    logic [OFF_W-1:0]  in_off;
    logic [LEN_W-1:0]  in_len;

    assign in_ip    = s_axis_tdata[31:0];
    assign in_slot  = s_axis_tdata[47:32];
    assign in_start = s_axis_tdata[63:48];
    assign in_end   = s_axis_tdata[95:64];
    assign in_off   = s_axis_tdata[119:96];
    assign in_len   = s_axis_tdata[135:120];

    logic [IP_W-1:0]  rec_end;
    logic [OFF_W-1:0] rec_off;
    logic [LEN_W-1:0] rec_len;
    logic [CNT_W-1:0] pfx_start;
    logic [CNT_W-1:0] idx_inc;
    logic             accept;
    logic             hit;
    logic             start_past;
    logic             scan_end;
    logic             out_free;

    assign rec_end    = rec_rdata[REC_W-1 -: IP_W];
    assign rec_off    = rec_rdata[LEN_W +: OFF_W];
    assign rec_len    = rec_rdata[LEN_W-1:0];
    assign pfx_start  = {1'b0, pfx_rdata};
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign hit        = rec_end >= addr_reg;
    assign start_past = pfx_start >= limit;
    assign scan_end   = idx_inc >= limit;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign accept     = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_axis_tuser == CMD_LOOKUP) begin
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                state_next = start_past ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (hit || scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and memory ports
    always_comb begin
        s_axis_tready  = 1'b0;
        pfx_port.we    = 1'b0;
        pfx_port.waddr = in_slot;
        pfx_port.wdata = in_start;
        pfx_port.raddr = in_ip[IP_W-1 -: PFX_AW];
        rec_port.we    = 1'b0;
        rec_port.waddr = in_slot;
        rec_port.wdata = {in_end, in_off, in_len};
        rec_port.raddr = idx_inc[REC_AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                pfx_port.we   = s_axis_tvalid && s_axis_tuser == CMD_PREFIX;
                rec_port.we   = s_axis_tvalid && s_axis_tuser == CMD_RECORD;
            end
            ST_PREFIX: begin
                rec_port.raddr = pfx_rdata;
            end
            ST_SCAN: begin
                rec_port.raddr = idx_inc[REC_AW-1:0];
            end
            ST_DONE: begin
                s_axis_tready = 1'b0;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        res_off_next = res_off_reg;
        res_len_next = res_len_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_found_next = m_found_reg;
        m_off_next   = m_off_reg;
        m_len_next   = m_len_reg;
        case (state_reg)
            ST_IDLE: begin
                addr_next    = in_ip;
                res_off_next = '0;
                res_len_next = '0;
            end
            ST_PREFIX: begin
                idx_next = pfx_start;
            end
            ST_SCAN: begin
                if (hit) begin
                    res_off_next = rec_off;
                    res_len_next = rec_len;
                end else begin
                    idx_next = idx_inc;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    // a zero length record counts as no match
                    m_valid_next = 1'b1;
                    m_found_next = res_len_reg != '0;
                    m_off_next   = (res_len_reg != '0) ? res_off_reg : '0;
                    m_len_next   = res_len_reg;
                end
            end
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        idx_reg     <= idx_next;
        res_off_reg <= res_off_next;
        res_len_reg <= res_len_next;
        m_found_reg <= m_found_next;
        m_off_reg   <= m_off_next;
        m_len_reg   <= m_len_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = {m_len_reg, m_off_reg};

endmodule

FILE: src/ip_range_lookup.sv
`timescale 1ns / 1ps

// channel   | dir | handshake                      | payload
// ----------+-----+--------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tuser command, tdata request fields
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tuser found, tdata text offset, length
// cfg       | in  | cfg_wr_en                      | cfg_wr_data record count
//
// a prefix or record write is stored at once and the block stays idle; unknown commands are dropped
// a lookup steps through prefix, scan and done states, examining k records (0 when the start is
// at or past the count); the record memory's single read port fetches one record per cycle
// reset clears the controller and the result valid; both tables hold garbage until written
// a finished result waits in the output register; a new request is taken while it waits,
// but the next lookup result cannot leave its final cycle until the register is free

module ip_range_lookup (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iprl_pkg::CNT_W-1:0]          cfg_wr_data,   // record count
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ip_address, slot, start_record, end_address, text_offset_in, text_length_in
    input  logic [iprl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic [iprl_pkg::CMD_W-1:0]          s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [iprl_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // text_offset, text_length
    output logic                                m_axis_tuser   // found
);

    import iprl_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] limit;

    pfx_port_t         pfx_port;
    rec_port_t         rec_port;
    logic [REC_AW-1:0] pfx_rdata;
    logic [REC_W-1:0]  rec_rdata;

    // configuration register
    always_comb begin
        count_next = cfg_wr_en ? cfg_wr_data : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // a count beyond the table depth scans to the end of the table
    assign limit = (count_reg > REC_LIMIT) ? REC_LIMIT : count_reg;

    // prefix index: top 16 address bits to first record
    iprl_ram #(
        .DATA_W (REC_AW),
        .ADDR_W (PFX_AW)
    ) u_pfx_ram (
        .aclk  (aclk),
        .we    (pfx_port.we),
        .waddr (pfx_port.waddr),
        .wdata (pfx_port.wdata),
        .raddr (pfx_port.raddr),
        .rdata (pfx_rdata)
    );

    // range records: end address, text offset, text length
    iprl_ram #(
        .DATA_W (REC_W),
        .ADDR_W (REC_AW)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_port.we),
        .waddr (rec_port.waddr),
        .wdata (rec_port.wdata),
        .raddr (rec_port.raddr),
        .rdata (rec_rdata)
    );

    // request sequencing, scan loop and output register
    iprl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .limit         (limit),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pfx_port      (pfx_port),
        .rec_port      (rec_port),
        .pfx_rdata     (pfx_rdata),
        .rec_rdata     (rec_rdata)
    );

endmodule

FILE: src/iprl_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iprl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [iprl_pkg::CMD_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [iprl_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    import iprl_pkg::*;

    logic               in_acc;
    logic               out_stall;
    logic [M_TDATA_W:0] out_word;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `IPRL_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_axis_tvalid, "result valid after reset")
    `IPRL_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled result changed")
    `IPRL_ASSERT(a_lookup_blocks, in_acc && s_axis_tuser == CMD_LOOKUP |=> !s_axis_tready, "ready after lookup request")
    `IPRL_ASSERT(a_write_ready, in_acc && s_axis_tuser != CMD_LOOKUP |=> s_axis_tready, "not ready after write request")
    `IPRL_ASSERT(a_no_instant_result, $rose(m_axis_tvalid) |-> !$past(in_acc), "result right after request")

endmodule

bind ip_range_lookup iprl_checker u_iprl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
